// File: rtl/ula_rtf_pkg.sv
// Shared types and raster constants for the ULA raster timing flags block.
// Depends on nothing; every other file in rtl refers to it by scoped names.
`timescale 1ns / 1ps

package ula_rtf_pkg;

  localparam int unsigned ScreenWidthDefault  = 720;
  localparam int unsigned ScreenHeightDefault = 288;

  localparam int unsigned TactW  = 18;
  localparam int unsigned CountW = 9;
  localparam int unsigned FlagsW = 8;

  // Line and frame geometry.
  localparam logic [CountW-1:0] LineDotLast = 9'd455;
  localparam logic [CountW-1:0] LastLine50  = 9'd310;
  localparam logic [CountW-1:0] LastLine60  = 9'd263;

  // Visible area.
  localparam logic [CountW-1:0] VisXFirst   = 9'd96;
  localparam logic [CountW-1:0] VisXLast    = 9'h1c7;
  localparam logic [CountW-1:0] VisYFirst   = 9'd16;
  localparam logic [CountW-1:0] VisYLast50  = 9'h12f;
  localparam logic [CountW-1:0] VisYLast60  = 9'hff;

  // Display (bitmap) area and the fetch window that leads it.
  localparam logic [CountW-1:0] DispXFirst  = 9'd144;
  localparam logic [CountW-1:0] DispXLast   = 9'h18f;
  localparam logic [CountW-1:0] FetchXFirst = 9'd128;
  localparam logic [CountW-1:0] DispYFirst50 = 9'd64;
  localparam logic [CountW-1:0] DispYLast50  = 9'hff;
  localparam logic [CountW-1:0] DispYFirst60 = 9'd40;
  localparam logic [CountW-1:0] DispYLast60  = 9'he7;

  // Bit positions inside render_flags.
  localparam int unsigned FlagDisplay = 0;
  localparam int unsigned FlagContend = 1;
  localparam int unsigned FlagRegSamp = 2;
  localparam int unsigned FlagByte1   = 3;
  localparam int unsigned FlagByte2   = 4;
  localparam int unsigned FlagShift   = 5;
  localparam int unsigned FlagFloat   = 6;
  localparam int unsigned FlagBorder  = 7;

  // Frame position handed from the counter stage to the render stage.
  typedef struct packed {
    logic [TactW-1:0]  tact;
    logic [CountW-1:0] hc;
    logic [CountW-1:0] vc;
    logic              m60;
    logic              last;
  } pos_t;

endpackage

// File: rtl/ula_rtf_pos.sv
// Position counters and input register of the ULA raster timing flags block.
// Depends on ula_rtf_pkg for the geometry constants and pos_t.
`timescale 1ns / 1ps

module ula_rtf_pos (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_mode_60hz,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_frame_restart,
  output logic                s1_valid,
  input  logic                s1_ready,
  output ula_rtf_pkg::pos_t   s1_pos
);

  logic                                mode_60hz_r;
  logic [ula_rtf_pkg::CountW-1:0]      dot_r, dot_nxt;
  logic [ula_rtf_pkg::CountW-1:0]      line_r, line_nxt;
  logic [ula_rtf_pkg::TactW-1:0]       tact_r, tact_nxt;
  logic                                s1_valid_r, s1_valid_nxt;
  ula_rtf_pkg::pos_t                   s1_pos_r, s1_pos_nxt;

  logic [ula_rtf_pkg::CountW-1:0]      hc, vc, last_line;
  logic [ula_rtf_pkg::TactW-1:0]       tact;
  logic                                line_end, frame_end, accept;

  assign in_ready = !s1_valid_r || s1_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // A restart clears the position before this beat is evaluated.
    hc   = in_frame_restart ? '0 : dot_r;
    vc   = in_frame_restart ? '0 : line_r;
    tact = in_frame_restart ? '0 : tact_r;
    last_line = mode_60hz_r ? ula_rtf_pkg::LastLine60 : ula_rtf_pkg::LastLine50;
    line_end  = hc >= ula_rtf_pkg::LineDotLast;
    frame_end = line_end && (vc >= last_line);

    dot_nxt  = dot_r;
    line_nxt = line_r;
    tact_nxt = tact_r;
    s1_pos_nxt = s1_pos_r;
    s1_valid_nxt = s1_valid_r;
    if (s1_ready) begin
      s1_valid_nxt = 1'b0;
    end
    if (accept) begin
      s1_valid_nxt = 1'b1;
      s1_pos_nxt.tact = tact;
      s1_pos_nxt.hc   = hc;
      s1_pos_nxt.vc   = vc;
      s1_pos_nxt.m60  = mode_60hz_r;
      s1_pos_nxt.last = frame_end;
      if (frame_end) begin
        dot_nxt  = '0;
        line_nxt = '0;
        tact_nxt = '0;
      end else if (line_end) begin
        dot_nxt  = '0;
        line_nxt = vc + 9'd1;
        tact_nxt = tact + 18'd1;
      end else begin
        dot_nxt  = hc + 9'd1;
        line_nxt = vc;
        tact_nxt = tact + 18'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_60hz_r <= 1'b0;
      dot_r       <= '0;
      line_r      <= '0;
      tact_r      <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_60hz_r <= cfg_mode_60hz;
      end
      dot_r      <= dot_nxt;
      line_r     <= line_nxt;
      tact_r     <= tact_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_pos_r <= s1_pos_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_pos   = s1_pos_r;

endmodule

// File: rtl/ula_rtf_render.sv
// Render flag decode, pixel index and result register of the ULA raster block.
// Depends on ula_rtf_pkg for the area constants, flag positions and pos_t.
`timescale 1ns / 1ps

module ula_rtf_render #(
  parameter int unsigned SCREEN_WIDTH  = ula_rtf_pkg::ScreenWidthDefault,
  parameter int unsigned SCREEN_HEIGHT = ula_rtf_pkg::ScreenHeightDefault
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              s1_valid,
  output logic                              s1_ready,
  input  ula_rtf_pkg::pos_t                 s1_pos,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ula_rtf_pkg::TactW-1:0]     out_tact_out,
  output logic [ula_rtf_pkg::CountW-1:0]    out_hc_out,
  output logic [ula_rtf_pkg::CountW-1:0]    out_vc_out,
  output logic [ula_rtf_pkg::FlagsW-1:0]    out_render_flags,
  output logic                              out_pixel_valid,
  output logic [ula_rtf_pkg::TactW-1:0]     out_pixel_index,
  output logic                              out_frame_last
);

  localparam int unsigned IdxW = 21;

  logic                               out_valid_r;
  logic [ula_rtf_pkg::TactW-1:0]      tact_r;
  logic [ula_rtf_pkg::CountW-1:0]     hc_r, vc_r;
  logic [ula_rtf_pkg::FlagsW-1:0]     flags_r, flags_nxt;
  logic                               pix_valid_r, pix_valid_nxt;
  logic [ula_rtf_pkg::TactW-1:0]      pix_idx_r, pix_idx_nxt;
  logic                               last_r;

  logic [ula_rtf_pkg::CountW-1:0]     hc, vc, vis_y_last, y_first, y_last, y_off, x_off;
  logic [3:0]                         sub, adj;
  logic                               visible, lines, disp, fetch;
  logic [IdxW-1:0]                    idx_wide;

  assign s1_ready = !out_valid_r || out_ready;

  always_comb begin
    hc  = s1_pos.hc;
    vc  = s1_pos.vc;
    sub = hc[3:0];
    adj = sub + 4'd1;
    vis_y_last = s1_pos.m60 ? ula_rtf_pkg::VisYLast60   : ula_rtf_pkg::VisYLast50;
    y_first    = s1_pos.m60 ? ula_rtf_pkg::DispYFirst60 : ula_rtf_pkg::DispYFirst50;
    y_last     = s1_pos.m60 ? ula_rtf_pkg::DispYLast60  : ula_rtf_pkg::DispYLast50;

    visible = (hc >= ula_rtf_pkg::VisXFirst) && (hc <= ula_rtf_pkg::VisXLast) &&
              (vc >= ula_rtf_pkg::VisYFirst) && (vc <= vis_y_last);
    lines   = (vc >= y_first) && (vc <= y_last);
    disp    = lines && (hc >= ula_rtf_pkg::DispXFirst) && (hc <= ula_rtf_pkg::DispXLast);
    fetch   = lines && (hc >= ula_rtf_pkg::FetchXFirst) && (hc <= ula_rtf_pkg::DispXLast);

    flags_nxt = '0;
    if (visible) begin
      flags_nxt[ula_rtf_pkg::FlagDisplay] = disp;
      flags_nxt[ula_rtf_pkg::FlagBorder]  = !disp;
      if (disp) begin
        flags_nxt[ula_rtf_pkg::FlagContend] = (adj[3:2] != 2'd0) || (adj[3:1] == 3'd0);
        flags_nxt[ula_rtf_pkg::FlagFloat]   = (sub == 4'd5) || (sub == 4'd7) ||
                                              (sub == 4'd9) || (sub == 4'd11);
      end
      if (fetch) begin
        flags_nxt[ula_rtf_pkg::FlagRegSamp] = (sub == 4'd7) || (sub == 4'd15);
        flags_nxt[ula_rtf_pkg::FlagByte1]   = (sub[1:0] == 2'd0);
        flags_nxt[ula_rtf_pkg::FlagByte2]   = (sub[1:0] == 2'd2);
        flags_nxt[ula_rtf_pkg::FlagShift]   = (sub == 4'd0) || (sub == 4'd8);
      end
    end

    // Offsets are only meaningful inside the visible area, where they cannot wrap.
    y_off = vc - ula_rtf_pkg::VisYFirst;
    x_off = hc - ula_rtf_pkg::VisXFirst;
    idx_wide = IdxW'(y_off) * IdxW'(SCREEN_WIDTH) + IdxW'({x_off, 1'b0});
    pix_valid_nxt = visible && ({1'b0, y_off} < 10'(SCREEN_HEIGHT));
    pix_idx_nxt   = pix_valid_nxt ? idx_wide[ula_rtf_pkg::TactW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_ready) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      tact_r      <= s1_pos.tact;
      hc_r        <= hc;
      vc_r        <= vc;
      flags_r     <= flags_nxt;
      pix_valid_r <= pix_valid_nxt;
      pix_idx_r   <= pix_idx_nxt;
      last_r      <= s1_pos.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tact_out     = tact_r;
  assign out_hc_out       = hc_r;
  assign out_vc_out       = vc_r;
  assign out_render_flags = flags_r;
  assign out_pixel_valid  = pix_valid_r;
  assign out_pixel_index  = pix_idx_r;
  assign out_frame_last   = last_r;

endmodule

// File: rtl/ula_raster_timing_flags.sv
// Top level of the ULA raster timing flags block: counter stage plus render stage.
// Depends on ula_rtf_pkg, ula_rtf_pos and ula_rtf_render.
`timescale 1ns / 1ps

// Usage:
// Every beat on the input channel is one dot tick. The block reports the frame
// position of that tick (tact, horizontal and vertical count), the eight render
// flags, the framebuffer index of the pixel pair drawn there and a last-tact
// marker, then advances the position by one dot, wrapping at 456 dots a line and
// 311 (50 Hz) or 264 (60 Hz) lines a frame. Setting in_frame_restart on a beat
// moves the position to tact zero before that beat is reported.
// An input beat passes two registers on its way to the result beat: the first holds
// the position, the second holds the decoded result. One beat is taken every
// cycle for as long as the receiver keeps out_ready high.
// When the receiver stalls, the result register holds its beat and the position
// register behind it fills; in_ready then drops until out_ready returns, and no
// beat is lost or repeated. The configuration write channel always accepts; the
// mode is sampled with each input beat and should be changed only while idle.
// Reset (rst_n low, synchronous) clears the counters to tact zero, selects 50 Hz
// timing and empties both registers.
module ula_raster_timing_flags #(
  parameter int unsigned SCREEN_WIDTH  = ula_rtf_pkg::ScreenWidthDefault,
  parameter int unsigned SCREEN_HEIGHT = ula_rtf_pkg::ScreenHeightDefault
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_mode_60hz,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_frame_restart,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ula_rtf_pkg::TactW-1:0]     out_tact_out,
  output logic [ula_rtf_pkg::CountW-1:0]    out_hc_out,
  output logic [ula_rtf_pkg::CountW-1:0]    out_vc_out,
  output logic [ula_rtf_pkg::FlagsW-1:0]    out_render_flags,
  output logic                              out_pixel_valid,
  output logic [ula_rtf_pkg::TactW-1:0]     out_pixel_index,
  output logic                              out_frame_last
);

  logic              s1_valid;
  logic              s1_ready;
  ula_rtf_pkg::pos_t s1_pos;

  // The mode register has no busy condition, so a write completes at once.
  assign cfg_ready = 1'b1;

  ula_rtf_pos u_pos (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_mode_60hz    (cfg_mode_60hz),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_frame_restart (in_frame_restart),
    .s1_valid         (s1_valid),
    .s1_ready         (s1_ready),
    .s1_pos           (s1_pos)
  );

  ula_rtf_render #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_render (
    .clk              (clk),
    .rst_n            (rst_n),
    .s1_valid         (s1_valid),
    .s1_ready         (s1_ready),
    .s1_pos           (s1_pos),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tact_out     (out_tact_out),
    .out_hc_out       (out_hc_out),
    .out_vc_out       (out_vc_out),
    .out_render_flags (out_render_flags),
    .out_pixel_valid  (out_pixel_valid),
    .out_pixel_index  (out_pixel_index),
    .out_frame_last   (out_frame_last)
  );

endmodule

// File: bench/tb_ula_raster_timing_flags.sv
// Self-checking bench for ula_raster_timing_flags: ticks through directed and random runs.
// A class mirrors the raster counters to predict each result beat. Depends on ula_rtf_pkg.
`timescale 1ns / 1ps

module tb_ula_raster_timing_flags;
  import ula_rtf_pkg::*;

  localparam int unsigned SCREEN_W = ScreenWidthDefault;
  localparam int unsigned SCREEN_H = ScreenHeightDefault;
  // The bitmap area fits in 18 bits with the default screen size.
  localparam logic [31:0] IndexMask = 32'h3ffff;

  // One result beat, laid out as the output ports carry it.
  typedef struct packed {
    logic [TactW-1:0]  tact;
    logic [CountW-1:0] hc;
    logic [CountW-1:0] vc;
    logic [FlagsW-1:0] flags;
    logic              pix_valid;
    logic [TactW-1:0]  pix_index;
    logic              last;
  } raster_beat_t;

  // Keeps its own copy of the frame position and the frame mode, works out the
  // beat that each accepted tick must produce, and checks result beats in order.
  class raster_position_mirror;
    bit                mode60;
    logic [CountW-1:0] dot_pos;
    logic [CountW-1:0] line_pos;
    logic [TactW-1:0]  tact_pos;
    raster_beat_t      pending_beats[$];
    int unsigned       fail_count;

    function new();
      mode60 = 1'b0;
      dot_pos = '0;
      line_pos = '0;
      tact_pos = '0;
      fail_count = 0;
    endfunction

    function void set_mode(bit m);
      mode60 = m;
    endfunction

    function int unsigned waiting();
      return pending_beats.size();
    endfunction

    // Render flags for one position. Everything outside the visible area is zero;
    // inside it a dot is either display or border, and the fetch window leads the
    // display window by one character cell.
    function logic [FlagsW-1:0] flags_at(bit m60, logic [CountW-1:0] vc,
                                         logic [CountW-1:0] hc);
      logic [CountW-1:0] vis_y_last;
      logic [CountW-1:0] y_first;
      logic [CountW-1:0] y_last;
      logic [3:0]        sub;
      logic [3:0]        adj;
      bit                lines;
      bit                disp;
      bit                fetch;
      logic [FlagsW-1:0] f;
      vis_y_last = m60 ? VisYLast60 : VisYLast50;
      y_first = m60 ? DispYFirst60 : DispYFirst50;
      y_last = m60 ? DispYLast60 : DispYLast50;
      sub = hc[3:0];
      f = '0;
      if (hc < VisXFirst || hc > VisXLast || vc < VisYFirst || vc > vis_y_last) begin
        return f;
      end
      lines = (vc >= y_first) && (vc <= y_last);
      disp = lines && (hc >= DispXFirst) && (hc <= DispXLast);
      fetch = lines && (hc >= FetchXFirst) && (hc <= DispXLast);
      if (disp) begin
        f[FlagDisplay] = 1'b1;
        adj = sub + 4'd1;
        if (adj[3:2] != 2'd0 || adj[3:1] == 3'd0) f[FlagContend] = 1'b1;
        if (sub == 4'd5 || sub == 4'd7 || sub == 4'd9 || sub == 4'd11) begin
          f[FlagFloat] = 1'b1;
        end
      end else begin
        f[FlagBorder] = 1'b1;
      end
      if (fetch) begin
        if (sub == 4'd7 || sub == 4'd15) f[FlagRegSamp] = 1'b1;
        if (sub[1:0] == 2'd0) f[FlagByte1] = 1'b1;
        if (sub[1:0] == 2'd2) f[FlagByte2] = 1'b1;
        if (sub == 4'd0 || sub == 4'd8) f[FlagShift] = 1'b1;
      end
      return f;
    endfunction

    // Called once per accepted input beat: report the current position, then step it.
    function void note_tick(bit restart);
      raster_beat_t      e;
      logic [CountW-1:0] last_line;
      int unsigned       row;
      int unsigned       col;
      logic [31:0]       idx;
      if (restart) begin
        dot_pos = '0;
        line_pos = '0;
        tact_pos = '0;
      end
      last_line = mode60 ? LastLine60 : LastLine50;
      e.tact = tact_pos;
      e.hc = dot_pos;
      e.vc = line_pos;
      e.flags = flags_at(mode60, line_pos, dot_pos);
      e.pix_valid = 1'b0;
      e.pix_index = '0;
      if (e.flags != '0 && line_pos >= VisYFirst && dot_pos >= VisXFirst) begin
        row = 32'(line_pos - VisYFirst);
        col = 32'(dot_pos - VisXFirst);
        if (row < SCREEN_H) begin
          idx = (row * SCREEN_W + col * 2) & IndexMask;
          e.pix_valid = 1'b1;
          e.pix_index = idx[TactW-1:0];
        end
      end
      // A line beyond the last one of the current mode (left over from a mode
      // change) counts as the last line, so its final dot ends the frame.
      e.last = (dot_pos >= LineDotLast) && (line_pos >= last_line);
      pending_beats.push_back(e);

      if (dot_pos >= LineDotLast) begin
        dot_pos = '0;
        if (line_pos >= last_line) begin
          line_pos = '0;
          tact_pos = '0;
        end else begin
          line_pos = line_pos + 1'b1;
          tact_pos = tact_pos + 1'b1;
        end
      end else begin
        dot_pos = dot_pos + 1'b1;
        tact_pos = tact_pos + 1'b1;
      end
    endfunction

    task report_error(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      fail_count++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want,
                       logic [TactW-1:0] at_tact);
      if (got !== want) begin
        report_error($sformatf("%s is %0h, want %0h (tact %0d)", name, got, want, at_tact));
      end
    endtask

    task check_beat(raster_beat_t got);
      raster_beat_t want;
      if (pending_beats.size() == 0) begin
        report_error($sformatf("result beat with nothing pending (tact %0d)", got.tact));
        return;
      end
      want = pending_beats.pop_front();
      compare_field("tact_out", 32'(got.tact), 32'(want.tact), want.tact);
      compare_field("hc_out", 32'(got.hc), 32'(want.hc), want.tact);
      compare_field("vc_out", 32'(got.vc), 32'(want.vc), want.tact);
      compare_field("render_flags", 32'(got.flags), 32'(want.flags), want.tact);
      compare_field("pixel_valid", 32'(got.pix_valid), 32'(want.pix_valid), want.tact);
      compare_field("pixel_index", 32'(got.pix_index), 32'(want.pix_index), want.tact);
      compare_field("frame_last", 32'(got.last), 32'(want.last), want.tact);
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_mode_60hz;
  logic                in_valid;
  logic                in_ready;
  logic                in_frame_restart;
  logic                out_valid;
  logic                out_ready;
  logic [TactW-1:0]    out_tact_out;
  logic [CountW-1:0]   out_hc_out;
  logic [CountW-1:0]   out_vc_out;
  logic [FlagsW-1:0]   out_render_flags;
  logic                out_pixel_valid;
  logic [TactW-1:0]    out_pixel_index;
  logic                out_frame_last;

  raster_position_mirror mirror = new();

  // Receiver behavior, steered from the stimulus process: the percentage of
  // result beats that are preceded by a random stall, and a one-shot long stall.
  int unsigned rx_gap_pct = 0;
  int unsigned long_stall = 0;

  ula_raster_timing_flags #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_mode_60hz   (cfg_mode_60hz),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_frame_restart(in_frame_restart),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_tact_out    (out_tact_out),
    .out_hc_out      (out_hc_out),
    .out_vc_out      (out_vc_out),
    .out_render_flags(out_render_flags),
    .out_pixel_valid (out_pixel_valid),
    .out_pixel_index (out_pixel_index),
    .out_frame_last  (out_frame_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Each side draws a random wait for a beat; gap_pct sets how often that draw is
  // made at all, so phases range from fully dense to a draw for every beat.
  function automatic int unsigned draw_wait(int unsigned gap_pct);
    if ($urandom_range(99, 0) < gap_pct) return $urandom_range(9, 0);
    return 0;
  endfunction

  // One input beat. Valid is only lowered when a gap is actually taken, so a
  // back-to-back beat never sees valid dropped and raised in the same step.
  task automatic send_tick(bit restart, int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame_restart <= restart;
    do @(posedge clk); while (in_ready !== 1'b1);
    mirror.note_tick(restart);
  endtask

  // A run of ticks; restart_pm is the chance of a frame restart per thousand beats.
  task automatic run_ticks(int unsigned count, int unsigned restart_pm,
                           int unsigned gap_pct);
    repeat (count) send_tick($urandom_range(999, 0) < restart_pm, draw_wait(gap_pct));
  endtask

  // Stop offering beats and wait until every predicted result has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    while (mirror.waiting() != 0) @(posedge clk);
  endtask

  // Mode writes happen only with the block drained, because the block samples
  // the mode with every input beat.
  task automatic write_mode(bit m60);
    cfg_valid <= 1'b1;
    cfg_mode_60hz <= m60;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    mirror.set_mode(m60);
  endtask

  // Result side: every beat is checked against the oldest prediction. A long
  // stall requested by the stimulus is counted out here, in this process.
  initial begin : result_sink
    int unsigned  hold;
    raster_beat_t got;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = (long_stall != 0) ? long_stall : draw_wait(rx_gap_pct);
      long_stall = 0;
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.tact = out_tact_out;
      got.hc = out_hc_out;
      got.vc = out_vc_out;
      got.flags = out_render_flags;
      got.pix_valid = out_pixel_valid;
      got.pix_index = out_pixel_index;
      got.last = out_frame_last;
      mirror.check_beat(got);
    end
  end

  initial begin : stimulus
    int unsigned chunk;
    int unsigned tx_gap;
    int unsigned restart_pm;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_mode_60hz <= 1'b0;
    in_valid <= 1'b0;
    in_frame_restart <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed start. The first beats run from the reset position with the reset
    // mode, then restarts land mid-line, back to back and after a gap.
    repeat (3) send_tick(1'b0, 0);
    send_tick(1'b1, 0);
    send_tick(1'b0, 3);
    send_tick(1'b0, 0);
    send_tick(1'b0, 9);
    send_tick(1'b1, 0);
    send_tick(1'b1, 1);
    send_tick(1'b1, 0);
    send_tick(1'b0, 0);
    // The receiver now takes its one-shot long stall while beats keep coming, so both
    // internal registers fill and in_ready has to drop.
    long_stall = 40;
    repeat (12) send_tick(1'b0, 0);
    drain();
    write_mode(1'b0);

    // Random part: chunks with a random mode, random idling on both sides and
    // restarts that range from never to frequent.
    for (chunk = 0; chunk < 7; chunk++) begin
      write_mode(1'($urandom_range(1, 0)));
      case ($urandom_range(2, 0))
        0: tx_gap = 0;
        1: tx_gap = 30;
        default: tx_gap = 100;
      endcase
      case ($urandom_range(2, 0))
        0: rx_gap_pct = 0;
        1: rx_gap_pct = 30;
        default: rx_gap_pct = 100;
      endcase
      case ($urandom_range(2, 0))
        0: restart_pm = 0;
        1: restart_pm = 4;
        default: restart_pm = 60;
      endcase
      run_ticks(250, restart_pm, tx_gap);
      drain();
    end

    // Idle on so that any stray beat the block might still emit shows up.
    repeat (8) @(posedge clk);
    if (mirror.waiting() != 0) mirror.report_error("predicted results never arrived");
    if (mirror.fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run, with every beat taking the
  // longest gap on both sides.
  initial begin : watchdog
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
